FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL; clk and rst_n come from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define LRUKL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition in a cycle implies another in the same cycle.
`define LRUKL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/lrukl_pkg.sv
package lrukl_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LIMIT_W  = 7;

    localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(50);

    typedef struct packed {
        logic                mode;
        logic [KEY_BITS-1:0] key;
    } lrukl_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic             evicted;
    } lrukl_result_t;

endpackage

FILE: design/lru_key_list_core.sv
// LRU key list: keys ordered oldest (position 0) to newest, bounded by a limit.
//
// Command channel: present mode and key with start high; the transaction is
// taken at a rising edge where start is high and busy is low. mode 0 looks
// the key up; mode 1 refreshes it as newest or appends it, dropping the oldest
// key when the list is at its limit.
// Result: done pulses for one cycle with found, position, entry_count and
// evicted. The receiver cannot stall; it must capture the result on that cycle.
// Operation: the search walks the key store from the newest entry down, one
// entry per cycle through its single read port. A move to the newest end then
// shifts later entries down one per cycle and writes the key. busy stays high
// from the accepting edge through the last search, shift or write step, with
// done in the next cycle; no new transaction is taken while busy. A lookup on
// an empty list finishes without a search. busy is low again in the done cycle.
// Configuration: cfg_we writes list_limit from cfg_wdata (0 means 50, values
// above 64 act as 64); write only while idle.
// Reset: the list is empty and list_limit is 50; the key store is not cleared.
module lru_key_list_core
    import lrukl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LIMIT_W-1:0]  cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic                mode,
    input  logic [KEY_BITS-1:0] key,
    output logic                done,
    output logic                found,
    output logic [IDX_W-1:0]    position,
    output logic [CNT_W-1:0]    entry_count,
    output logic                evicted
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_raw;
    logic [CNT_W-1:0]   limit_eff;
    lrukl_req_t         req;
    lrukl_result_t      result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= DEFAULT_LIMIT;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Zero selects the default; clamp to the store depth.
    always_comb
    begin
        limit_raw = (limit_reg == '0) ? DEFAULT_LIMIT : limit_reg;
        if ({1'b0, limit_raw} > (LIMIT_W + 1)'(CAPACITY))
        begin
            limit_eff = CNT_W'(CAPACITY);
        end
        else
        begin
            limit_eff = CNT_W'(limit_raw);
        end
    end

    assign req.mode = mode;
    assign req.key  = key;

    lrukl_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .limit  (limit_eff),
        .busy   (busy),
        .result (result)
    );

    assign done        = result.done;
    assign found       = result.found;
    assign position    = result.pos;
    assign entry_count = result.count;
    assign evicted     = result.evicted;

endmodule

FILE: design/lrukl_ram.sv
module lrukl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/lrukl_seq.sv
module lrukl_seq
    import lrukl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lrukl_req_t       req,
    input  logic [CNT_W-1:0] limit,
    output logic             busy,
    output lrukl_result_t    result
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_APPEND = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic                mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic                evict_reg, evict_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                grow_reg, grow_next;
    logic                done_reg, done_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    logic                term;
    logic                t_found;
    logic [IDX_W-1:0]    t_pos;
    logic                d_mode;
    logic [IDX_W-1:0]    s_idx;
    logic                do_shift;

    lrukl_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        count_next = count_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        evict_next = evict_reg;
        idx_next   = idx_reg;
        grow_next  = grow_reg;
        done_next  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = idx_reg - 1'b1;
        term       = 1'b0;
        t_found    = 1'b0;
        t_pos      = '0;
        d_mode     = mode_reg;
        s_idx      = '0;
        do_shift   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                d_mode = req.mode;
                if (start)
                begin
                    mode_next  = req.mode;
                    key_next   = req.key;
                    evict_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        term = 1'b1;
                    end
                    else
                    begin
                        // Newest entry first; its data returns next cycle.
                        ram_raddr  = IDX_W'(count_reg - 1'b1);
                        idx_next   = IDX_W'(count_reg - 1'b1);
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (ram_rdata == key_reg)
                begin
                    term    = 1'b1;
                    t_found = 1'b1;
                    t_pos   = idx_reg;
                end
                else if (idx_reg == '0)
                begin
                    term = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_SHIFT:
            begin
                // Move entry idx+1 down into idx while fetching the next one.
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + 1'b1;
                if (CNT_W'(idx_reg) + CNT_W'(2) == count_reg)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    ram_raddr = idx_reg + IDX_W'(2);
                end
            end
            ST_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = key_reg;
                if (grow_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (term)
        begin
            found_next = t_found;
            pos_next   = t_pos;
            grow_next  = 1'b0;
            priority if (!d_mode || (t_found && (CNT_W'(t_pos) + 1'b1 == count_reg)))
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            else if (t_found)
            begin
                do_shift = 1'b1;
                s_idx    = t_pos;
            end
            else if (count_reg >= limit && count_reg != '0)
            begin
                evict_next = 1'b1;
                do_shift   = 1'b1;
                s_idx      = '0;
            end
            else
            begin
                idx_next   = IDX_W'(count_reg);
                grow_next  = 1'b1;
                state_next = ST_APPEND;
            end
        end

        if (do_shift)
        begin
            idx_next = s_idx;
            if (CNT_W'(s_idx) + 1'b1 == count_reg)
            begin
                // Nothing above the removed entry: write the key in place.
                state_next = ST_APPEND;
            end
            else
            begin
                ram_raddr  = s_idx + 1'b1;
                state_next = ST_SHIFT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        evict_reg <= evict_next;
        idx_reg   <= idx_next;
        grow_reg  <= grow_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result.done    = done_reg;
    assign result.found   = found_reg;
    assign result.pos     = pos_reg;
    assign result.count   = count_reg;
    assign result.evicted = evict_reg;

    `LRUKL_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `LRUKL_ASSERT_IMPLY(a_write_state, ram_we, state_reg == ST_SHIFT || state_reg == ST_APPEND,
        "key store written outside shift or append")
    `LRUKL_ASSERT_IMPLY(a_done_idle, done_reg, state_reg == ST_IDLE, "result while still busy")
    `LRUKL_ASSERT_IMPLY(a_evict_add, done_reg && evict_reg, mode_reg && !found_reg,
        "eviction reported without a new key added")

endmodule
